[design/fmq_pkg.sv]
// Package for the FIFO-queued mutex: codes, the FSM state type and the cell command.
// Has no dependencies. Every other file in design/ imports it.
`default_nettype none
package fmq_pkg;

	localparam int unsigned ID_W = 8;
	localparam logic [ID_W-1:0] NO_OWNER = 8'hFF;
	localparam logic [ID_W-1:0] LIMIT_RESET = 8'd32;

	typedef enum logic [1:0] {
		KIND_LOCK   = 2'd0,
		KIND_UNLOCK = 2'd1,
		KIND_CANCEL = 2'd2,
		KIND_NONE   = 2'd3
	} fmq_kind_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_REFUSED   = 2'd1,
		STAT_NOT_FOUND = 2'd2
	} fmq_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP,
		ST_SCAN
	} fmq_state_t;

	// Broadcast to every cell of the queue chain
	typedef struct packed {
		logic            shift;     // every cell takes its right neighbor's id
		logic            probe_en;  // probe token moves one cell toward the tail
		logic            probe_clr; // drop the probe token
		logic            mark;      // probed cell with a matching id becomes cancelled
		logic [ID_W-1:0] tid;
	} fmq_cell_cmd_t;

endpackage
`default_nettype wire

[design/fmq_if.sv]
// Channel interfaces of the FIFO-queued mutex: request, response, configuration write.
// Depends on fmq_pkg.
`default_nettype none
interface fmq_req_if import fmq_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [1:0]      kind;
	logic [ID_W-1:0] tid;

	modport source (output valid, kind, tid, input ready);
	modport sink   (input valid, kind, tid, output ready);
endinterface

interface fmq_rsp_if import fmq_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [1:0]      status;
	logic [ID_W-1:0] owner;
	logic            locked;
	logic [5:0]      waiting;

	modport source (output valid, status, owner, locked, waiting, input ready);
	modport sink   (input valid, status, owner, locked, waiting, output ready);
endinterface

interface fmq_cfg_if import fmq_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [ID_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

[design/fmq_cell.sv]
// One entry of the wait queue chain: a thread id that shifts toward the head,
// plus the probe token used by the cancel search. Depends on fmq_pkg.
`default_nettype none
module fmq_cell
	import fmq_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire fmq_cell_cmd_t   cmd,
	input  wire logic            append_sel,
	input  wire logic [ID_W-1:0] next_id,
	input  wire logic            probe_in,
	output logic      [ID_W-1:0] id,
	output logic                 probe,
	output logic                 hit
);

	logic [ID_W-1:0] id_q;
	logic            probe_q;

	assign hit   = probe_q && (id_q == cmd.tid);
	assign id    = id_q;
	assign probe = probe_q;

	always_ff @(posedge clk) begin
		priority if (cmd.shift) begin
			id_q <= next_id;
		end else if (append_sel) begin
			id_q <= cmd.tid;
		end else if (cmd.mark && hit) begin
			id_q <= NO_OWNER;
		end else begin
			id_q <= id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= 1'b0;
		end else if (cmd.probe_clr) begin
			probe_q <= 1'b0;
		end else if (cmd.probe_en) begin
			probe_q <= probe_in;
		end
	end

endmodule
`default_nettype wire

[design/fifo_mutex_with_wait_queue.sv]
// Mutex with a FIFO wait queue held in a chain of cells, head at cell 0; depends on
// fmq_pkg, fmq_if and fmq_cell.
//
// One request is handled at a time. A request is taken only while the block is idle and
// its result lands in an output register, so a held result does not stop the next
// request being taken, though it cannot finish until the held result is taken.
// A lock and a refusal are settled in the execute state. An unlock (or a cancel by the
// owner) first drops the cancelled entries at the queue head, the chain shifting one
// entry per cycle, and then passes ownership on. A cancel of a queued thread walks a
// probe token down the chain one cell per cycle while the output register is free, up
// to the match, or to the queue fill when there is none. The block is idle again once
// the result is written. The configuration register is always ready.
`default_nettype none
module fifo_mutex_with_wait_queue
	import fmq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 32
) (
	input wire logic  clk,
	input wire logic  arst_n,
	fmq_req_if.sink   req,
	fmq_rsp_if.source rsp,
	fmq_cfg_if.sink   cfg
);

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	fmq_state_t      state_q, state_d;
	logic [ID_W-1:0] limit_q;
	logic [ID_W-1:0] owner_q, owner_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] scan_n_q, scan_n_d;
	logic [1:0]      kind_q;
	logic [ID_W-1:0] tid_q;

	logic            rsp_valid_q;
	logic [1:0]      rsp_status_q;
	logic [ID_W-1:0] rsp_owner_q;
	logic [CNT_W-1:0] rsp_count_q;

	logic            res_free;
	logic            res_we;
	fmq_status_t     res_status;

	fmq_cell_cmd_t   cmd;
	logic            append;
	logic            probe_start;
	logic [ID_W-1:0] cell_id [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] cell_probe;
	logic [QUEUE_DEPTH-1:0] cell_hit;
	logic [QUEUE_DEPTH-1:0] append_sel;
	logic            hit_any;

	assign res_free = !rsp_valid_q || rsp.ready;
	assign hit_any  = |cell_hit;

	assign req.ready   = (state_q == ST_IDLE);
	assign cfg.ready   = 1'b1;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.status  = rsp_status_q;
	assign rsp.owner   = rsp_owner_q;
	assign rsp.locked  = (rsp_owner_q != NO_OWNER);
	assign rsp.waiting = 6'(rsp_count_q);

	// Cell chain
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [ID_W-1:0] next_id;
		logic            probe_in;

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign next_id = NO_OWNER;
		end else begin : g_mid
			assign next_id = cell_id[i+1];
		end
		if (i == 0) begin : g_head
			assign probe_in = probe_start;
		end else begin : g_body
			assign probe_in = cell_probe[i-1];
		end

		assign append_sel[i] = append && (count_q == CNT_W'(i));

		fmq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.append_sel(append_sel[i]),
			.next_id   (next_id),
			.probe_in  (probe_in),
			.id        (cell_id[i]),
			.probe     (cell_probe[i]),
			.hit       (cell_hit[i])
		);
	end

	always_comb begin
		state_d       = state_q;
		owner_d       = owner_q;
		count_d       = count_q;
		scan_n_d      = scan_n_q;
		res_we        = 1'b0;
		res_status    = STAT_OK;
		append        = 1'b0;
		probe_start   = 1'b0;
		cmd           = '0;
		cmd.tid       = tid_q;

		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (kind_q)
					KIND_LOCK: begin
						if (res_free) begin
							res_we  = 1'b1;
							state_d = ST_IDLE;
							priority if (tid_q >= limit_q || tid_q == owner_q) begin
								res_status = STAT_REFUSED;
							end else if (owner_q == NO_OWNER) begin
								owner_d = tid_q;
							end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
								res_status = STAT_REFUSED;
							end else begin
								append  = 1'b1;
								count_d = count_q + 1'b1;
							end
						end
					end
					KIND_UNLOCK, KIND_CANCEL: begin
						if (owner_q != NO_OWNER && tid_q == owner_q) begin
							state_d = ST_POP;
						end else if (kind_q == KIND_CANCEL && tid_q != owner_q) begin
							state_d      = ST_SCAN;
							scan_n_d     = '0;
							probe_start  = 1'b1;
							cmd.probe_en = 1'b1;
						end else if (res_free) begin
							res_we     = 1'b1;
							res_status = STAT_REFUSED;
							state_d    = ST_IDLE;
						end
					end
					default: begin
						if (res_free) begin
							res_we     = 1'b1;
							res_status = STAT_REFUSED;
							state_d    = ST_IDLE;
						end
					end
				endcase
			end
			ST_POP: begin
				// cancelled heads drain one per cycle, then ownership passes to the next waiter or the mutex is freed
				priority if (count_q == '0) begin
					if (res_free) begin
						owner_d = NO_OWNER;
						res_we  = 1'b1;
						state_d = ST_IDLE;
					end
				end else if (cell_id[0] == NO_OWNER) begin
					cmd.shift = 1'b1;
					count_d   = count_q - 1'b1;
				end else begin
					if (res_free) begin
						owner_d   = cell_id[0];
						cmd.shift = 1'b1;
						count_d   = count_q - 1'b1;
						res_we    = 1'b1;
						state_d   = ST_IDLE;
					end
				end
			end
			ST_SCAN: begin
				if (res_free) begin
					priority if (scan_n_q == count_q) begin
						res_status    = STAT_NOT_FOUND;
						res_we        = 1'b1;
						cmd.probe_clr = 1'b1;
						state_d       = ST_IDLE;
					end else if (hit_any) begin
						cmd.mark      = 1'b1;
						res_we        = 1'b1;
						cmd.probe_clr = 1'b1;
						state_d       = ST_IDLE;
					end else begin
						cmd.probe_en = 1'b1;
						scan_n_d     = scan_n_q + 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			limit_q     <= LIMIT_RESET;
			owner_q     <= NO_OWNER;
			count_q     <= '0;
			scan_n_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			owner_q  <= owner_d;
			count_q  <= count_d;
			scan_n_q <= scan_n_d;
			if (cfg.valid) begin
				limit_q <= cfg.data;
			end
			if (res_we) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_q <= req.kind;
			tid_q  <= req.tid;
		end
		if (res_we) begin
			rsp_status_q <= res_status;
			rsp_owner_q  <= owner_d;
			rsp_count_q  <= count_d;
		end
	end

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue fill above depth");

	a_probe_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_probe))
		else $error("more than one probe token in the chain");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> scan_n_q <= count_q)
		else $error("cancel search ran past the queue fill");

	a_result_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |=> $stable(rsp_status_q) && $stable(rsp_owner_q))
		else $error("held result overwritten");

endmodule
`default_nettype wire

[verif/fmq_lock_check.sv]
// Checker for the FIFO-queued mutex: watches the request, response and config channels,
// predicts each response from its own copy of the owner, wait queue and thread_limit.
// Depends on fmq_pkg and fmq_if.
module fmq_lock_check import fmq_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 32
) (
	input wire logic    clk,
	input wire logic    arst_n,
	fmq_req_if          req,
	fmq_rsp_if          rsp,
	fmq_cfg_if          cfg,
	output int unsigned fail_count,
	output int unsigned pending,
	output int unsigned checked,
	output int unsigned peak_waiting,
	output int unsigned full_refusals,
	output int unsigned limit_writes
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		fmq_status_t     status;
		logic [ID_W-1:0] owner;
		logic            locked;
		logic [5:0]      waiting;
	} mutex_view_t;

	logic [ID_W-1:0] thread_limit = LIMIT_RESET;
	logic [ID_W-1:0] holder = NO_OWNER;
	logic [ID_W-1:0] waiters[$];    // head at index 0; NO_OWNER marks a cancelled entry
	mutex_view_t     views_due[$];
	int unsigned     errs = 0;
	int unsigned     n_checked = 0;
	int unsigned     n_full = 0;
	int unsigned     n_writes = 0;
	int unsigned     peak = 0;

	function automatic fmq_status_t release_mutex(input logic [ID_W-1:0] t);
		if (holder == NO_OWNER || t != holder)
			return STAT_REFUSED;
		while (waiters.size() != 0 && waiters[0] == NO_OWNER)
			void'(waiters.pop_front());
		if (waiters.size() != 0)
			holder = waiters.pop_front();
		else
			holder = NO_OWNER;
		return STAT_OK;
	endfunction

	function automatic fmq_status_t take_lock(input logic [ID_W-1:0] t);
		if (t >= thread_limit || t == holder)
			return STAT_REFUSED;
		if (holder == NO_OWNER) begin
			holder = t;
			return STAT_OK;
		end
		if (waiters.size() >= QUEUE_DEPTH) begin
			n_full++;
			return STAT_REFUSED;
		end
		waiters.push_back(t);
		return STAT_OK;
	endfunction

	// Owner cancel acts as unlock; else the first matching waiter is marked cancelled.
	// A cancel for NO_OWNER while locked matches an already cancelled entry.
	function automatic fmq_status_t cancel_wait(input logic [ID_W-1:0] t);
		if (holder == t)
			return release_mutex(t);
		foreach (waiters[i]) begin
			if (waiters[i] == t) begin
				waiters[i] = NO_OWNER;
				return STAT_OK;
			end
		end
		return STAT_NOT_FOUND;
	endfunction

	function automatic mutex_view_t predict_view(input fmq_kind_t k, input logic [ID_W-1:0] t);
		mutex_view_t v;
		case (k)
			KIND_LOCK:   v.status = take_lock(t);
			KIND_UNLOCK: v.status = release_mutex(t);
			KIND_CANCEL: v.status = cancel_wait(t);
			default:     v.status = STAT_REFUSED;
		endcase
		v.owner = holder;
		v.locked = (holder != NO_OWNER);
		v.waiting = 6'(waiters.size());
		if (waiters.size() > peak)
			peak = waiters.size();
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		mutex_view_t due;
		if (!arst_n) begin
			thread_limit = LIMIT_RESET;
			holder = NO_OWNER;
			waiters.delete();
			views_due.delete();
		end else begin
			// a response can never belong to a request taken in the same cycle
			if (rsp.valid && rsp.ready) begin
				n_checked++;
				if (views_due.size() == 0) begin
					errs++;
					$error("response with nothing outstanding: status %0d owner %0d waiting %0d",
						rsp.status, rsp.owner, rsp.waiting);
				end else begin
					due = views_due.pop_front();
					if (rsp.status !== due.status) begin
						errs++;
						$error("status: expected %0d, got %0d", due.status, rsp.status);
					end
					if (rsp.owner !== due.owner) begin
						errs++;
						$error("owner: expected %0d, got %0d", due.owner, rsp.owner);
					end
					if (rsp.locked !== due.locked) begin
						errs++;
						$error("locked: expected %0d, got %0d", due.locked, rsp.locked);
					end
					if (rsp.waiting !== due.waiting) begin
						errs++;
						$error("waiting: expected %0d, got %0d", due.waiting, rsp.waiting);
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				thread_limit = cfg.data;
				n_writes++;
			end
			if (req.valid && req.ready)
				views_due.push_back(predict_view(fmq_kind_t'(req.kind), req.tid));
		end
		// outputs are assigned nonblocking so the stimulus side reads them free of races
		fail_count <= errs;
		pending <= views_due.size();
		checked <= n_checked;
		peak_waiting <= peak;
		full_refusals <= n_full;
		limit_writes <= n_writes;
	end

endmodule

[verif/tb_top.sv]
// Testbench top for the FIFO-queued mutex: clock, reset, request and config stimulus,
// response back-pressure, watchdog and verdict. Depends on fmq_pkg, fmq_if, the block
// and fmq_lock_check.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import fmq_pkg::*;

	localparam int unsigned QDEPTH = 32;
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned SETTLE_CYCLES = QDEPTH + 4;
	localparam int unsigned PHASE_ITEMS = 165;

	logic clk = 1'b0;
	logic arst_n;

	fmq_req_if req_ch ();
	fmq_rsp_if rsp_ch ();
	fmq_cfg_if cfg_ch ();

	int unsigned fail_count, pending, checked, peak_waiting, full_refusals, limit_writes;
	int unsigned sent_cnt = 0;
	int unsigned burst_left = 0;
	int unsigned quiet_cycles = 0;

	always #1 clk = ~clk;

	fifo_mutex_with_wait_queue #(.QUEUE_DEPTH(QDEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	fmq_lock_check #(.QUEUE_DEPTH(QDEPTH)) lock_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.cfg           (cfg_ch),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked       (checked),
		.peak_waiting  (peak_waiting),
		.full_refusals (full_refusals),
		.limit_writes  (limit_writes)
	);

	// Sender: bursts of random length separated by random gaps.
	task automatic offer(input fmq_kind_t k, input logic [ID_W-1:0] t);
		if (burst_left == 0) begin
			req_ch.valid <= 1'b0;
			repeat (($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3))
				@(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 10);
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.kind <= k;
		req_ch.tid <= t;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sent_cnt++;
	endtask

	// Stop offering and hold until every response is back and the block is idle.
	task automatic settle();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [ID_W-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic fmq_kind_t pick_kind();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return KIND_LOCK;
		if (r < 75)
			return KIND_UNLOCK;
		if (r < 96)
			return KIND_CANCEL;
		return KIND_NONE;
	endfunction

	// Mostly a small pool of ids so requests collide; some NO_OWNER and full-range ids.
	function automatic logic [ID_W-1:0] pick_tid(input int unsigned pool_top);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return ID_W'($urandom_range(0, pool_top));
		if (r < 86)
			return NO_OWNER;
		return ID_W'($urandom_range(0, 255));
	endfunction

	initial begin : stimulus
		logic [ID_W-1:0] phase_limits[6];
		int unsigned     pool_top, phase_end, pick, run, base;
		phase_limits[0] = LIMIT_RESET;
		phase_limits[1] = 8'd255;
		phase_limits[2] = 8'd1;
		phase_limits[3] = ID_W'($urandom_range(2, 254));
		phase_limits[4] = 8'd5;
		phase_limits[5] = 8'd128;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.kind <= KIND_LOCK;
		req_ch.tid <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: free-mutex refusals, limit edge, relock, queueing, cancel marks
		offer(KIND_UNLOCK, 8'd0);
		offer(KIND_CANCEL, NO_OWNER);
		offer(KIND_CANCEL, 8'd5);
		offer(KIND_LOCK, NO_OWNER);
		offer(KIND_LOCK, 8'd32);
		offer(KIND_LOCK, 8'd31);
		offer(KIND_LOCK, 8'd31);
		offer(KIND_LOCK, 8'd0);
		offer(KIND_LOCK, 8'd1);
		offer(KIND_LOCK, 8'd2);
		offer(KIND_CANCEL, 8'd1);
		offer(KIND_CANCEL, NO_OWNER);
		offer(KIND_CANCEL, 8'd7);
		offer(KIND_UNLOCK, 8'd0);
		offer(KIND_NONE, 8'd31);
		offer(KIND_UNLOCK, 8'd31);
		offer(KIND_UNLOCK, 8'd0);
		offer(KIND_CANCEL, 8'd2);
		offer(KIND_LOCK, 8'd254);
		settle();
		write_limit(8'd255);
		offer(KIND_LOCK, 8'd254);
		offer(KIND_LOCK, 8'd128);
		offer(KIND_LOCK, 8'd0);
		settle();
		// waiter 128 inherits the mutex although it is now beyond thread_limit
		write_limit(8'd1);
		offer(KIND_UNLOCK, 8'd254);
		offer(KIND_LOCK, 8'd1);
		offer(KIND_CANCEL, 8'd0);
		offer(KIND_UNLOCK, 8'd128);

		for (int p = 0; p < 6; p++) begin
			settle();
			write_limit(phase_limits[p]);
			pool_top = $urandom_range(2, 7);
			phase_end = sent_cnt + PHASE_ITEMS;
			while (sent_cnt < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					// lock storm: can push the wait queue to full
					run = $urandom_range(30, 45);
					repeat (run) offer(KIND_LOCK, ID_W'($urandom_range(0, pool_top)));
				end else if (pick < 14) begin
					// unlocks cycling the pool: hits the owner regularly and drains the queue
					run = $urandom_range(10, 40);
					base = $urandom_range(0, pool_top);
					for (int j = 0; j < run; j++)
						offer(KIND_UNLOCK, ID_W'((base + j) % (pool_top + 1)));
				end else begin
					offer(pick_kind(), pick_tid(pool_top));
				end
			end
		end
		settle();

		$display("%0d responses checked under %0d thread_limit writes (1, 255 and others)",
			checked, limit_writes);
		$display("wait queue peaked at %0d of %0d entries, %0d locks refused on a full queue",
			peak_waiting, QDEPTH, full_refusals);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Receiver: stretches of steady, random and no ready; long hold-offs fill the block.
	initial begin : receiver
		int unsigned mode, span;
		bit          long_hold_done;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ((!long_hold_done && sent_cnt >= 250) || $urandom_range(0, 299) == 0) begin
				long_hold_done = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(150, 300)) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 9);
				span = (mode < 8) ? $urandom_range(1, 40) : $urandom_range(1, 12);
				repeat (span) begin
					if (mode < 4)
						rsp_ch.ready <= 1'b1;
					else if (mode < 8)
						rsp_ch.ready <= 1'($urandom_range(0, 1));
					else
						rsp_ch.ready <= 1'b0;
					@(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("no transaction for %0d cycles, %0d responses still due",
				quiet_cycles, pending);
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule
